FILE: rtl/core/jsmd_pkg.sv
// ----------------------------------------------------------------------------
// jsmd_pkg
// Shared widths, reset values, codes and types of the job shop makespan
// decoder.
// ----------------------------------------------------------------------------
package jsmd_pkg;

  // default sizes handed to the top level
  localparam int unsigned MAX_JOBS_DEF     = 16;
  localparam int unsigned MAX_MACHINES_DEF = 16;
  localparam int unsigned TIME_BITS_DEF    = 24;

  // fixed payload widths
  localparam int unsigned JOB_W     = 4;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned MC_W      = 4;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned MS_W      = 24;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_W-1:0] NUM_JOBS_RST     = 5'd16;
  localparam logic [CFG_W-1:0] NUM_MACHINES_RST = 5'd16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_GENE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_JOBS     = 4'd0,
    CFG_NUM_MACHINES = 4'd1
  } cfg_reg_e;

  // task entry as read back from the table
  typedef struct packed {
    logic [MC_W-1:0]  machine;
    logic [DUR_W-1:0] duration;
    logic             mc_bad;
  } task_rd_t;

endpackage

FILE: rtl/core/jsmd_if.sv
// ----------------------------------------------------------------------------
// jsmd interfaces
// Valid/ready channels of the decoder: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface jsmd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [jsmd_pkg::JOB_W-1:0]  job;
  logic [jsmd_pkg::OP_W-1:0]   op_index;
  logic [jsmd_pkg::MC_W-1:0]   machine;
  logic [jsmd_pkg::DUR_W-1:0]  duration;
  logic                        last;

  modport source (output valid, mode, job, op_index, machine, duration, last,
                  input ready);
  modport sink   (input valid, mode, job, op_index, machine, duration, last,
                  output ready);
endinterface

interface jsmd_out_if;
  logic                       valid;
  logic                       ready;
  logic [jsmd_pkg::MS_W-1:0]  makespan;
  logic                       bad_gene;

  modport source (output valid, makespan, bad_gene, input ready);
  modport sink   (input valid, makespan, bad_gene, output ready);
endinterface

interface jsmd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [jsmd_pkg::CFG_IDX_W-1:0] index;
  logic [jsmd_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/job_shop_makespan_decoder.sv
// ----------------------------------------------------------------------------
// job_shop_makespan_decoder: one item per cycle through a 3-stage pipeline
// a last gene passes stage 1 and stage 2, then its result goes to the output register
// rate set by the machine-ready memory read-modify-write, forwarded per cycle
// input stalls only while a result waits and the next last gene is due to leave
// reset: config 16/16, job and machine times and counts zero, task table not cleared
// ----------------------------------------------------------------------------
module job_shop_makespan_decoder #(
  parameter int unsigned MAX_JOBS     = jsmd_pkg::MAX_JOBS_DEF,
  parameter int unsigned MAX_MACHINES = jsmd_pkg::MAX_MACHINES_DEF,
  parameter int unsigned TIME_BITS    = jsmd_pkg::TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsmd_in_if.sink    in_i,
  jsmd_out_if.source out_o,
  jsmd_cfg_if.sink   cfg_i
);

  localparam int unsigned JIW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned MIW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned OPIW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned NOPW = $clog2(MAX_MACHINES + 1);
  localparam int unsigned SUMW =
      ((TIME_BITS > jsmd_pkg::DUR_W) ? TIME_BITS : jsmd_pkg::DUR_W) + 1;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [jsmd_pkg::JOB_W-1:0] job;
    logic [NOPW-1:0]            op;
    logic                       last;
    logic                       err;
    time_t                      jr;
  } s1_t;

  typedef struct packed {
    logic [jsmd_pkg::JOB_W-1:0] job;
    logic [jsmd_pkg::MC_W-1:0]  mc;
    logic [jsmd_pkg::DUR_W-1:0] dur;
    logic                       last;
    logic                       err;
    time_t                      jr;
    logic                       mr_fwd;
    logic                       mr_zero;
    time_t                      mr_fv;
  } s2_t;

  localparam time_t TMAX = {TIME_BITS{1'b1}};

  // configuration
  logic [jsmd_pkg::CFG_W-1:0] num_jobs_q;
  logic [jsmd_pkg::CFG_W-1:0] num_machines_q;

  // per-chromosome state
  logic [NOPW-1:0] nop_q [MAX_JOBS];
  logic [NOPW-1:0] nop_d [MAX_JOBS];
  time_t           jr_q  [MAX_JOBS];
  time_t           mr_mem [MAX_MACHINES];
  logic            mr_vld_q [MAX_MACHINES];
  time_t           mr_rd_q;
  time_t           run_ms_q;
  logic            err_seen_q;

  // pipeline
  logic  s1_vld_q, s2_vld_q;
  s1_t   s1_q, s1_d;
  s2_t   s2_q, s2_d;
  jsmd_pkg::task_rd_t task_rd;

  logic  out_valid_q;
  logic [jsmd_pkg::MS_W-1:0] out_ms_q;
  logic  out_bad_q;

  logic            adv;
  logic            in_acc, gene0, load0;
  logic [JIW-1:0]  jidx0;
  logic [NOPW-1:0] nop_eff;
  logic            job_bad0, op_bad0, err0;
  logic            s1_fix;
  logic            s2_go, s2_clear, s2_wr;
  time_t           mr_eff, start2, end2, ms_fin;
  logic [SUMW-1:0] sum2;

  // stall only while a finished result waits and another one is due
  assign adv = !(s2_vld_q && s2_q.last && out_valid_q && !out_o.ready);

  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  assign in_acc = in_i.valid && adv;
  assign gene0  = in_acc && (in_i.mode == jsmd_pkg::MODE_GENE);
  assign load0  = in_acc && (in_i.mode == jsmd_pkg::MODE_LOAD);
  assign jidx0  = JIW'(in_i.job);

  // undo the op count of a gene whose task names a machine at or beyond MAX_MACHINES
  assign s1_fix = s1_vld_q && !s1_q.err && !s1_q.last && task_rd.mc_bad;

  assign nop_eff = (s1_fix && (s1_q.job == in_i.job)) ? s1_q.op : nop_q[jidx0];

  assign job_bad0 = (32'(in_i.job) >= 32'(num_jobs_q))
                 || (32'(in_i.job) >= 32'(MAX_JOBS));
  assign op_bad0  = (32'(nop_eff) >= 32'(num_machines_q))
                 || (32'(nop_eff) >= 32'(MAX_MACHINES));
  assign err0     = job_bad0 || op_bad0;

  assign s2_go    = adv && s2_vld_q;
  assign s2_clear = s2_go && s2_q.last;
  assign s2_wr    = s2_go && !s2_q.err && !s2_q.last;

  jsmd_task_table #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES)
  ) u_task_table (
    .clk_i      (clk_i),
    .wr_en_i    (load0),
    .rd_en_i    (gene0),
    .job_i      (in_i.job),
    .wr_op_i    (in_i.op_index),
    .rd_op_i    (OPIW'(nop_eff)),
    .machine_i  (in_i.machine),
    .duration_i (in_i.duration),
    .rd_o       (task_rd)
  );

  // stage 2: start, end, makespan
  always_comb begin
    if (s2_q.mr_fwd) begin
      mr_eff = s2_q.mr_fv;
    end else if (s2_q.mr_zero) begin
      mr_eff = '0;
    end else begin
      mr_eff = mr_rd_q;
    end
    start2 = (mr_eff > s2_q.jr) ? mr_eff : s2_q.jr;
    sum2   = SUMW'(start2) + SUMW'(s2_q.dur);
    end2   = ((sum2 >> TIME_BITS) != '0) ? TMAX : TIME_BITS'(sum2);
    ms_fin = (!s2_q.err && (end2 > run_ms_q)) ? end2 : run_ms_q;
  end

  // stage captures with forwarding from the committing gene
  always_comb begin
    s1_d.job  = in_i.job;
    s1_d.op   = nop_eff;
    s1_d.last = in_i.last;
    s1_d.err  = err0;
    if (s2_clear) begin
      s1_d.jr = '0;
    end else if (s2_wr && (s2_q.job == in_i.job)) begin
      s1_d.jr = end2;
    end else begin
      s1_d.jr = jr_q[jidx0];
    end

    s2_d.job  = s1_q.job;
    s2_d.mc   = task_rd.machine;
    s2_d.dur  = task_rd.duration;
    s2_d.last = s1_q.last;
    s2_d.err  = s1_q.err || task_rd.mc_bad;
    if (s2_clear) begin
      s2_d.jr = '0;
    end else if (s2_wr && (s2_q.job == s1_q.job)) begin
      s2_d.jr = end2;
    end else begin
      s2_d.jr = s1_q.jr;
    end
    s2_d.mr_fwd  = s2_wr && (s2_q.mc == task_rd.machine);
    s2_d.mr_zero = s2_clear || !mr_vld_q[MIW'(task_rd.machine)];
    s2_d.mr_fv   = end2;
  end

  // op counts: restore, count the taken gene, restart on a last gene
  always_comb begin
    nop_d = nop_q;
    if (s1_fix) begin
      nop_d[JIW'(s1_q.job)] = s1_q.op;
    end
    if (gene0 && !err0) begin
      nop_d[jidx0] = nop_eff + NOPW'(1);
    end
    // counts restart as soon as the last gene is taken
    if (gene0 && in_i.last) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        nop_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_jobs_q     <= jsmd_pkg::NUM_JOBS_RST;
      num_machines_q <= jsmd_pkg::NUM_MACHINES_RST;
    end else if (cfg_i.valid) begin
      case (jsmd_pkg::cfg_reg_e'(cfg_i.index))
        jsmd_pkg::CFG_NUM_JOBS:     num_jobs_q     <= cfg_i.data;
        jsmd_pkg::CFG_NUM_MACHINES: num_machines_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        nop_q[i] <= '0;
      end
    end else if (adv) begin
      nop_q <= nop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        jr_q[i] <= '0;
      end
      for (int i = 0; i < MAX_MACHINES; i++) begin
        mr_vld_q[i] <= 1'b0;
      end
      run_ms_q   <= '0;
      err_seen_q <= 1'b0;
    end else if (s2_clear) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        jr_q[i] <= '0;
      end
      for (int i = 0; i < MAX_MACHINES; i++) begin
        mr_vld_q[i] <= 1'b0;
      end
      run_ms_q   <= '0;
      err_seen_q <= 1'b0;
    end else if (s2_go) begin
      if (!s2_q.err) begin
        jr_q[JIW'(s2_q.job)]    <= end2;
        mr_vld_q[MIW'(s2_q.mc)] <= 1'b1;
      end
      run_ms_q   <= ms_fin;
      err_seen_q <= err_seen_q || s2_q.err;
    end
  end

  // machine ready memory
  always_ff @(posedge clk_i) begin
    if (s2_wr) begin
      mr_mem[MIW'(s2_q.mc)] <= end2;
    end
    if (adv) begin
      mr_rd_q <= mr_mem[MIW'(task_rd.machine)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= gene0;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_clear) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_clear) begin
      out_ms_q  <= ((ms_fin >> jsmd_pkg::MS_W) != '0) ? {jsmd_pkg::MS_W{1'b1}}
                                                       : jsmd_pkg::MS_W'(ms_fin);
      out_bad_q <= err_seen_q || s2_q.err;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.makespan = out_ms_q;
  assign out_o.bad_gene = out_bad_q;

`ifndef SYNTHESIS
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_vld_q && s2_q.last && adv))
    else $error("result raised without a committed last gene");

  a_makespan_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && !s2_q.err && !s2_q.last) |=> (run_ms_q >= $past(end2)))
    else $error("running makespan below a committed end time");

  a_fix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fix |-> (32'(s1_q.op) < 32'(MAX_MACHINES)))
    else $error("op count restore out of range");
`endif

endmodule

FILE: rtl/core/jsmd_task_table.sv
// ----------------------------------------------------------------------------
// jsmd_task_table
// Single-port task memory holding machine and duration per job and
// operation; range-checked loads, registered reads.
// ----------------------------------------------------------------------------
module jsmd_task_table #(
  parameter int unsigned MAX_JOBS     = jsmd_pkg::MAX_JOBS_DEF,
  parameter int unsigned MAX_MACHINES = jsmd_pkg::MAX_MACHINES_DEF,
  localparam int unsigned DEPTH = MAX_JOBS * MAX_MACHINES,
  localparam int unsigned SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned OPIW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic                         rd_en_i,
  input  logic [jsmd_pkg::JOB_W-1:0]   job_i,
  input  logic [jsmd_pkg::OP_W-1:0]    wr_op_i,
  input  logic [OPIW-1:0]              rd_op_i,
  input  logic [jsmd_pkg::MC_W-1:0]    machine_i,
  input  logic [jsmd_pkg::DUR_W-1:0]   duration_i,
  output jsmd_pkg::task_rd_t           rd_o
);

  localparam int unsigned EW = jsmd_pkg::MC_W + jsmd_pkg::DUR_W;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;
  logic          wr_ok;
  logic [SW-1:0] wr_slot;
  logic [SW-1:0] rd_slot;

  // loads outside the table are dropped
  assign wr_ok = wr_en_i && (32'(job_i) < 32'(MAX_JOBS))
                         && (32'(wr_op_i) < 32'(MAX_MACHINES));

  assign wr_slot = SW'(32'(job_i) * 32'(MAX_MACHINES) + 32'(wr_op_i));
  assign rd_slot = SW'(32'(job_i) * 32'(MAX_MACHINES) + 32'(rd_op_i));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_slot] <= {machine_i, duration_i};
    end else if (rd_en_i) begin
      rdata_q <= mem[rd_slot];
    end
  end

  assign rd_o.machine  = rdata_q[EW-1:jsmd_pkg::DUR_W];
  assign rd_o.duration = rdata_q[jsmd_pkg::DUR_W-1:0];
  assign rd_o.mc_bad   = 32'(rdata_q[EW-1:jsmd_pkg::DUR_W]) >= 32'(MAX_MACHINES);

endmodule
